// ----- hw/rtl/hsv_to_rgb_pixel_core_defines.svh -----
// Assertion macros for the HSV to GRB pixel converter.
`ifndef HSV_TO_RGB_PIXEL_CORE_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_CORE_DEFINES_SVH

// Checked only while out of reset.
`define HSVP_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("hsvp assertion failed");

// Checked at every edge, reset included.
`define HSVP_ASSERT_ANY(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("hsvp assertion failed");

`endif

// ----- hw/rtl/hsvp_pkg.sv -----
// Shared constants and types for the HSV to GRB pixel converter.
`default_nettype none
package hsvp_pkg;

	localparam int unsigned HUE_W      = 9;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned GRB_W      = 24;
	localparam int unsigned REM_W      = 6;
	localparam int unsigned QUO_W      = 4;
	localparam int unsigned K_W        = 13;
	localparam int unsigned A_W        = 15;
	localparam int unsigned N_W        = A_W + K_W;

	localparam int unsigned PCT_FULL   = 100;
	localparam int unsigned CHAN_MAX   = 255;
	localparam int unsigned SECTORS    = 6;
	localparam int unsigned SECTOR_DEG = 60;
	localparam int unsigned FULL_K     = SECTOR_DEG * PCT_FULL;

	// hue / 60 as (hue * 1093) >> 16, exact for hue < 512
	localparam int unsigned HUE_RECIP    = 1093;
	localparam int unsigned HUE_RECIP_SH = 16;
	localparam int unsigned HUE_PROD_W   = HUE_W + 11;

	// n / 600000 as ((n >> 6) * 7330078) >> 36, exact for n < 2^28
	localparam int unsigned DIV_PRE_SH = 6;
	localparam int unsigned DIV_RECIP  = 7330078;
	localparam int unsigned DIV_SH     = 36;
	localparam int unsigned DIV_PROD_W = (N_W - DIV_PRE_SH) + 23;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_en_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hsvp_decode.sv -----
// Front stages: clamp, hue sector split, per-channel numerator factors.
`default_nettype none
module hsvp_decode import hsvp_pkg::*; (
	input  wire logic              clk,
	input  wire pipe_en_t          en,
	input  wire logic [HUE_W-1:0]  hue_degrees,
	input  wire logic [PCT_W-1:0]  saturation_pct,
	input  wire logic [PCT_W-1:0]  value_pct,
	output sector_t                sector_s2,
	output logic     [A_W-1:0]     a_s2,
	output logic     [K_W-1:0]     kp_s2,
	output logic     [K_W-1:0]     kq_s2,
	output logic     [K_W-1:0]     kt_s2
);

	logic [HUE_PROD_W-1:0] hue_prod;
	logic [QUO_W-1:0]      quo;
	logic [HUE_W-1:0]      quo_deg;
	logic [HUE_W-1:0]      rem_full;
	logic [QUO_W-1:0]      sec_raw;
	logic [PCT_W-1:0]      sat_c;
	logic [PCT_W-1:0]      val_c;

	sector_t               sector_s1;
	logic [REM_W-1:0]      rem_s1;
	logic [PCT_W-1:0]      sat_s1;
	logic [PCT_W-1:0]      val_s1;

	logic [K_W-1:0]        rs;
	logic [K_W-1:0]        trs;
	logic [K_W-1:0]        ps;

	always_comb begin
		hue_prod = HUE_PROD_W'(hue_degrees) * HUE_PROD_W'(HUE_RECIP);
		quo      = hue_prod[HUE_RECIP_SH +: QUO_W];
		quo_deg  = HUE_W'(quo) * HUE_W'(SECTOR_DEG);
		rem_full = hue_degrees - quo_deg;
		sec_raw  = (quo >= QUO_W'(SECTORS)) ? quo - QUO_W'(SECTORS) : quo;
		sat_c    = (saturation_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : saturation_pct;
		val_c    = (value_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : value_pct;
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			sector_s1 <= sector_t'(sec_raw[2:0]);
			rem_s1    <= rem_full[REM_W-1:0];
			sat_s1    <= sat_c;
			val_s1    <= val_c;
		end
	end

	always_comb begin
		rs  = K_W'(rem_s1) * K_W'(sat_s1);
		trs = (K_W'(SECTOR_DEG) - K_W'(rem_s1)) * K_W'(sat_s1);
		ps  = K_W'(SECTOR_DEG) * K_W'(sat_s1);
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			sector_s2 <= sector_s1;
			a_s2      <= A_W'(CHAN_MAX) * A_W'(val_s1);
			kp_s2     <= K_W'(FULL_K) - ps;
			kq_s2     <= K_W'(FULL_K) - rs;
			kt_s2     <= K_W'(FULL_K) - trs;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hsvp_lane.sv -----
// One channel level: floor(a * k / 600000) over two stages.
`default_nettype none
module hsvp_lane import hsvp_pkg::*; (
	input  wire logic              clk,
	input  wire pipe_en_t          en,
	input  wire logic [A_W-1:0]    a_s2,
	input  wire logic [K_W-1:0]    k_s2,
	output logic      [CHAN_W-1:0] chan_s4
);

	logic [N_W-1:0]        n_s3;
	logic [DIV_PROD_W-1:0] quo_prod;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			n_s3 <= N_W'(a_s2) * N_W'(k_s2);
		end
	end

	assign quo_prod = DIV_PROD_W'(n_s3[N_W-1:DIV_PRE_SH]) * DIV_PROD_W'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			chan_s4 <= quo_prod[DIV_SH +: CHAN_W];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_pixel_core.sv -----
// HSV to GRB pixel converter top level: five-stage pipeline, one pixel per clock unless stalled.
// Takes hue in degrees (0..511, wrapping every 360), saturation and value in
// percent (above 100 treated as 100) and returns a 24-bit word, green 23-16,
// red 15-8, blue 7-0, each channel 255 times its fraction, truncated, exact.
// One beat can enter every clock unless in_stall is high; its result passes
// through all five register stages before out_valid rises.
// The five register stages are: clamp and hue sector split,
// numerator factors, 15x13 multiply, reciprocal multiply for the constant
// divide, and the output register with the sector swizzle.
// Empty stages close up, so beats keep entering while a result waits on
// out_stall until the pipeline is full. Reset affects only the valid bits.
`default_nettype none
module hsv_to_rgb_pixel_core import hsvp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [HUE_W-1:0]  hue_degrees,
	input  wire logic [PCT_W-1:0]  saturation_pct,
	input  wire logic [PCT_W-1:0]  value_pct,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [GRB_W-1:0]  grb_word
);

	pipe_en_t          en;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic              valid_s5;

	sector_t           sector_s2;
	sector_t           sector_s3;
	sector_t           sector_s4;
	logic [A_W-1:0]    a_s2;
	logic [K_W-1:0]    kp_s2;
	logic [K_W-1:0]    kq_s2;
	logic [K_W-1:0]    kt_s2;
	logic [CHAN_W-1:0] cv_s4;
	logic [CHAN_W-1:0] cp_s4;
	logic [CHAN_W-1:0] cq_s4;
	logic [CHAN_W-1:0] ct_s4;
	logic [CHAN_W-1:0] r_c;
	logic [CHAN_W-1:0] g_c;
	logic [CHAN_W-1:0] b_c;
	logic [GRB_W-1:0]  grb_s5;

	always_comb begin
		en.en_s5 = !valid_s5 || !out_stall;
		en.en_s4 = !valid_s4 || en.en_s5;
		en.en_s3 = !valid_s3 || en.en_s4;
		en.en_s2 = !valid_s2 || en.en_s3;
		en.en_s1 = !valid_s1 || en.en_s2;
	end

	assign in_stall  = !en.en_s1;
	assign out_valid = valid_s5;
	assign grb_word  = grb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.en_s1) valid_s1 <= in_valid;
			if (en.en_s2) valid_s2 <= valid_s1;
			if (en.en_s3) valid_s3 <= valid_s2;
			if (en.en_s4) valid_s4 <= valid_s3;
			if (en.en_s5) valid_s5 <= valid_s4;
		end
	end

	hsvp_decode u_decode (
		.clk            (clk),
		.en             (en),
		.hue_degrees    (hue_degrees),
		.saturation_pct (saturation_pct),
		.value_pct      (value_pct),
		.sector_s2      (sector_s2),
		.a_s2           (a_s2),
		.kp_s2          (kp_s2),
		.kq_s2          (kq_s2),
		.kt_s2          (kt_s2)
	);

	hsvp_lane u_lane_v (
		.clk     (clk),
		.en      (en),
		.a_s2    (a_s2),
		.k_s2    (K_W'(FULL_K)),
		.chan_s4 (cv_s4)
	);

	hsvp_lane u_lane_p (
		.clk     (clk),
		.en      (en),
		.a_s2    (a_s2),
		.k_s2    (kp_s2),
		.chan_s4 (cp_s4)
	);

	hsvp_lane u_lane_q (
		.clk     (clk),
		.en      (en),
		.a_s2    (a_s2),
		.k_s2    (kq_s2),
		.chan_s4 (cq_s4)
	);

	hsvp_lane u_lane_t (
		.clk     (clk),
		.en      (en),
		.a_s2    (a_s2),
		.k_s2    (kt_s2),
		.chan_s4 (ct_s4)
	);

	always_ff @(posedge clk) begin
		if (en.en_s3) sector_s3 <= sector_s2;
		if (en.en_s4) sector_s4 <= sector_s3;
	end

	always_comb begin
		case (sector_s4)
			SEC_RED_YEL: begin r_c = cv_s4; g_c = ct_s4; b_c = cp_s4; end
			SEC_YEL_GRN: begin r_c = cq_s4; g_c = cv_s4; b_c = cp_s4; end
			SEC_GRN_CYN: begin r_c = cp_s4; g_c = cv_s4; b_c = ct_s4; end
			SEC_CYN_BLU: begin r_c = cp_s4; g_c = cq_s4; b_c = cv_s4; end
			SEC_BLU_MAG: begin r_c = ct_s4; g_c = cp_s4; b_c = cv_s4; end
			default:     begin r_c = cv_s4; g_c = cp_s4; b_c = cq_s4; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.en_s5) grb_s5 <= {g_c, r_c, b_c};
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hsvp_checker.sv -----
// Port-level checker for the HSV to GRB pixel converter, bound to the top level.
`default_nettype none
`include "hsv_to_rgb_pixel_core_defines.svh"
module hsvp_checker import hsvp_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [GRB_W-1:0] grb_word
);

	// a held result keeps its beat
	`HSVP_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(grb_word))

	// input only backs up when the output is full and blocked
	`HSVP_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall)

	// while input and output both stay stalled with a valid input waiting, out_valid is high
	`HSVP_ASSERT(a_stall_full, clk, arst_n, in_stall && in_valid && $past(out_stall) && out_stall && $past(in_stall) |-> out_valid)

	// reset empties the pipe at once
	`HSVP_ASSERT_ANY(a_reset_empty, clk, !arst_n |-> !out_valid && !in_stall)

endmodule

bind hsv_to_rgb_pixel_core hsvp_checker u_hsvp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.grb_word  (grb_word)
);
`default_nettype wire
